// ===== hdl/tld_pkg.sv =====
// ----------------------------------------------------------------------------
// tld_pkg
// Shared widths, register indexes and interface structs of the thermal lying
// detector.
// ----------------------------------------------------------------------------
package tld_pkg;

   localparam int PIX_W      = 8;
   localparam int ROOM_W     = 2;
   localparam int ROW_IDX_W  = 3;
   localparam int RUN_W      = 4;
   localparam int CNT_W      = 8;
   localparam int CSR_DATA_W = 8;
   localparam int CSR_IDX_W  = 2;

   localparam logic [RUN_W-1:0] RUN_MAX = '1;
   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HOT_LEVEL  = 2'd0,
      CSR_RUN_LENGTH = 2'd1,
      CSR_ON_FRAMES  = 2'd2,
      CSR_OFF_FRAMES = 2'd3
   } tld_csr_type;

   typedef struct packed {
      logic [PIX_W-1:0] hot_level;
      logic [RUN_W-1:0] run_length;
      logic [CNT_W-1:0] on_frames;
      logic [CNT_W-1:0] off_frames;
   } tld_cfg_type;

   typedef struct packed {
      logic take;
      logic last;
      logic line;
   } tld_scan_type;

   typedef struct packed {
      logic lying;
      logic changed;
   } tld_verdict_type;

endpackage

// ===== hdl/tld_if.sv =====
// ----------------------------------------------------------------------------
// tld_if
// Request and response channels of the thermal lying detector.
// ----------------------------------------------------------------------------
interface tld_req_if #(
   parameter int SIDE = 8
);
   logic                                valid;
   logic                                ready;
   logic [tld_pkg::ROOM_W-1:0]          room;
   logic [tld_pkg::ROW_IDX_W-1:0]       row_index;
   logic [SIDE*tld_pkg::PIX_W-1:0]      row_pixels;

   modport source  (output valid, room, row_index, row_pixels, input ready);
   modport sink    (input valid, room, row_index, row_pixels, output ready);
   modport monitor (input valid, ready, room, row_index, row_pixels);
endinterface

interface tld_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [tld_pkg::ROOM_W-1:0] out_room;
   logic                       line_seen;
   logic                       lying;
   logic                       changed;

   modport source  (output valid, out_room, line_seen, lying, changed, input ready);
   modport sink    (input valid, out_room, line_seen, lying, changed, output ready);
   modport monitor (input valid, ready, out_room, line_seen, lying, changed);
endinterface

// ===== hdl/tld_row_scan.sv =====
// ----------------------------------------------------------------------------
// tld_row_scan
// Row and column run detection for one frame row, with the per-column run
// lengths and the frame line flag.
// ----------------------------------------------------------------------------
module tld_row_scan #(
   parameter int SIDE = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  tld_pkg::tld_cfg_type              cfg,
   input  logic [tld_pkg::ROW_IDX_W-1:0]     row_index,
   input  logic [SIDE*tld_pkg::PIX_W-1:0]    row_pixels,
   output tld_pkg::tld_scan_type             scan
);
   import tld_pkg::*;

   localparam logic [ROW_IDX_W-1:0] LAST_ROW = ROW_IDX_W'(SIDE - 1);

   logic [RUN_W-1:0] col_run_ff [SIDE];
   logic [RUN_W-1:0] col_run_in [SIDE];
   logic             frame_line_ff;
   logic             frame_line_in;
   logic [RUN_W-1:0] need;
   logic [RUN_W-1:0] row_run;
   logic [RUN_W-1:0] col_base;
   logic             first;
   logic             hot;

   assign need  = (cfg.run_length == '0) ? RUN_W'(1) : cfg.run_length;
   assign first = (row_index == '0);

   always_comb begin
      row_run       = '0;
      col_base      = '0;
      hot           = 1'b0;
      frame_line_in = frame_line_ff & ~first;
      for (int c = 0; c < SIDE; c++) begin
         hot      = (row_pixels[c*PIX_W +: PIX_W] >= cfg.hot_level);
         col_base = first ? '0 : col_run_ff[c];
         if (hot) begin
            row_run       = row_run + RUN_W'(1);
            col_run_in[c] = (col_base == RUN_MAX) ? col_base : col_base + RUN_W'(1);
            if (row_run >= need || col_run_in[c] >= need) begin
               frame_line_in = 1'b1;
            end
         end else begin
            row_run       = '0;
            col_run_in[c] = '0;
         end
      end
   end

   assign scan.take = (32'(row_index) < SIDE);
   assign scan.last = (row_index == LAST_ROW);
   assign scan.line = frame_line_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_line_ff <= 1'b0;
         for (int c = 0; c < SIDE; c++) begin
            col_run_ff[c] <= '0;
         end
      end else if (advance && scan.take) begin
         if (scan.last) begin
            frame_line_ff <= 1'b0;
            for (int c = 0; c < SIDE; c++) begin
               col_run_ff[c] <= '0;
            end
         end else begin
            frame_line_ff <= frame_line_in;
            for (int c = 0; c < SIDE; c++) begin
               col_run_ff[c] <= col_run_in[c];
            end
         end
      end
   end

endmodule

// ===== hdl/tld_room_track.sv =====
// ----------------------------------------------------------------------------
// tld_room_track
// Per-room hit and miss counters and lying state, updated at frame end.
// ----------------------------------------------------------------------------
module tld_room_track #(
   parameter int ROOMS = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          update,
   input  tld_pkg::tld_cfg_type          cfg,
   input  logic [tld_pkg::ROOM_W-1:0]    room,
   input  logic                          line,
   output tld_pkg::tld_verdict_type      verdict
);
   import tld_pkg::*;

   logic [CNT_W-1:0] hit_ff   [ROOMS];
   logic [CNT_W-1:0] miss_ff  [ROOMS];
   logic             lying_ff [ROOMS];
   logic [CNT_W-1:0] hit_in;
   logic [CNT_W-1:0] miss_in;
   logic             lying_in;
   logic [CNT_W-1:0] sel_hit;
   logic [CNT_W-1:0] sel_miss;
   logic             sel_lying;
   logic             set_lying;
   logic             room_ok;

   assign room_ok = (32'(room) < ROOMS);

   always_comb begin
      sel_hit   = '0;
      sel_miss  = '0;
      sel_lying = 1'b0;
      for (int r = 0; r < ROOMS; r++) begin
         if (32'(room) == r) begin
            sel_hit   = hit_ff[r];
            sel_miss  = miss_ff[r];
            sel_lying = lying_ff[r];
         end
      end
   end

   always_comb begin
      if (line) begin
         hit_in  = (sel_hit == CNT_MAX) ? sel_hit : sel_hit + CNT_W'(1);
         miss_in = '0;
      end else begin
         hit_in  = '0;
         miss_in = (sel_miss == CNT_MAX) ? sel_miss : sel_miss + CNT_W'(1);
      end
      set_lying = sel_lying | (hit_in >= cfg.on_frames);
      lying_in  = set_lying & ~(miss_in >= cfg.off_frames);
   end

   assign verdict.lying   = room_ok & lying_in;
   assign verdict.changed = room_ok & (lying_in != sel_lying);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < ROOMS; r++) begin
            hit_ff[r]   <= '0;
            miss_ff[r]  <= '0;
            lying_ff[r] <= 1'b0;
         end
      end else if (update) begin
         for (int r = 0; r < ROOMS; r++) begin
            if (32'(room) == r) begin
               hit_ff[r]   <= hit_in;
               miss_ff[r]  <= miss_in;
               lying_ff[r] <= lying_in;
            end
         end
      end
   end

endmodule

// ===== hdl/thermal_lying_detector.sv =====
// ----------------------------------------------------------------------------
// thermal_lying_detector
// Detects a person lying down from line-shaped heat in a thermal frame.
// ----------------------------------------------------------------------------
// One frame row is taken per request, one request per cycle with no bubbles
// while the input is not stalled. A request is registered, scanned for row
// and column runs and, when it is the last row of a frame, used to update
// that room's counters; the response is registered from that update and is
// held until it is taken. The row scan is combinational on the request
// register; only a held response stalls the input, and only when the
// waiting row ends a frame. Other rows give no response.
module thermal_lying_detector #(
   parameter int SIDE  = 8,
   parameter int ROOMS = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   tld_req_if.sink                           req_chan,
   tld_rsp_if.source                         rsp_chan,
   input  logic                              csr_write_enable,
   input  logic [tld_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tld_pkg::CSR_DATA_W-1:0]    csr_write_data
);
   import tld_pkg::*;

   tld_cfg_type              cfg_ff;
   logic                     s1_valid_ff;
   logic [ROOM_W-1:0]        s1_room_ff;
   logic [ROW_IDX_W-1:0]     s1_row_ff;
   logic [SIDE*PIX_W-1:0]    s1_pix_ff;
   logic                     rsp_valid_ff;
   logic [ROOM_W-1:0]        rsp_room_ff;
   logic                     rsp_line_ff;
   logic                     rsp_lying_ff;
   logic                     rsp_changed_ff;
   logic                     advance;
   logic                     result_due;
   logic                     accept;
   tld_scan_type             scan;
   tld_verdict_type          verdict;

   assign result_due = scan.take & scan.last;
   assign advance    = s1_valid_ff & (~result_due | ~rsp_valid_ff | rsp_chan.ready);
   assign req_chan.ready = ~reset & (~s1_valid_ff | advance);
   assign accept     = req_chan.valid & req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hot_level  <= PIX_W'(2);
         cfg_ff.run_length <= RUN_W'(3);
         cfg_ff.on_frames  <= CNT_W'(5);
         cfg_ff.off_frames <= CNT_W'(5);
      end else if (csr_write_enable) begin
         unique case (tld_csr_type'(csr_index))
            CSR_HOT_LEVEL:  cfg_ff.hot_level  <= csr_write_data[PIX_W-1:0];
            CSR_RUN_LENGTH: cfg_ff.run_length <= csr_write_data[RUN_W-1:0];
            CSR_ON_FRAMES:  cfg_ff.on_frames  <= csr_write_data[CNT_W-1:0];
            CSR_OFF_FRAMES: cfg_ff.off_frames <= csr_write_data[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_room_ff <= req_chan.room;
         s1_row_ff  <= req_chan.row_index;
         s1_pix_ff  <= req_chan.row_pixels;
      end
   end

   tld_row_scan #(
      .SIDE (SIDE)
   ) u_row_scan (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .cfg        (cfg_ff),
      .row_index  (s1_row_ff),
      .row_pixels (s1_pix_ff),
      .scan       (scan)
   );

   tld_room_track #(
      .ROOMS (ROOMS)
   ) u_room_track (
      .clock   (clock),
      .reset   (reset),
      .update  (advance & result_due),
      .cfg     (cfg_ff),
      .room    (s1_room_ff),
      .line    (scan.line),
      .verdict (verdict)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && result_due) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && result_due) begin
         rsp_room_ff    <= s1_room_ff;
         rsp_line_ff    <= scan.line;
         rsp_lying_ff   <= verdict.lying;
         rsp_changed_ff <= verdict.changed;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.out_room  = rsp_room_ff;
   assign rsp_chan.line_seen = rsp_line_ff;
   assign rsp_chan.lying     = rsp_lying_ff;
   assign rsp_chan.changed   = rsp_changed_ff;

endmodule

// ===== hdl/tld_checker.sv =====
// ----------------------------------------------------------------------------
// tld_checker
// Port-level checks of the thermal lying detector, bound to the top level.
// ----------------------------------------------------------------------------
module tld_checker #(
   parameter int SIDE  = 8,
   parameter int ROOMS = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic [tld_pkg::ROW_IDX_W-1:0]   req_row_index,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [tld_pkg::ROOM_W-1:0]      rsp_out_room,
   input  logic                            rsp_line_seen,
   input  logic                            rsp_lying,
   input  logic                            rsp_changed
);
   import tld_pkg::*;

   localparam logic [ROW_IDX_W-1:0] LAST_ROW = ROW_IDX_W'(SIDE - 1);

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_room)
         && $stable(rsp_line_seen) && $stable(rsp_lying) && $stable(rsp_changed))
      else $error("held response dropped or altered");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (32'(rsp_out_room) >= ROOMS) |-> !rsp_lying && !rsp_changed)
      else $error("unknown room reports lying state");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) && !$past(reset) && !$past(reset, 2)
         |-> $past(req_valid && req_ready && req_row_index == LAST_ROW, 2))
      else $error("response without a last-row request");

endmodule

bind thermal_lying_detector tld_checker #(
   .SIDE  (SIDE),
   .ROOMS (ROOMS)
) u_tld_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .req_row_index (req_chan.row_index),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_out_room  (rsp_chan.out_room),
   .rsp_line_seen (rsp_chan.line_seen),
   .rsp_lying     (rsp_chan.lying),
   .rsp_changed   (rsp_chan.changed)
);
